// ===== design/vfjm_pkg.sv =====
package vfjm_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Result event codes.
  localparam logic [1:0] EV_FIRST  = 2'd0;
  localparam logic [1:0] EV_SECOND = 2'd1;
  localparam logic [1:0] EV_JANK   = 2'd2;
  localparam logic [1:0] EV_STATS  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_NOTIFY = 2'd0;
  localparam logic [1:0] REG_IDLE   = 2'd1;
  localparam logic [1:0] REG_RECORD = 2'd2;
  localparam logic [1:0] REG_STALE  = 2'd3;

  localparam int FIRST_LIMIT = 8;
  localparam int FIRST_DEPTH = FIRST_LIMIT + 1;
  localparam int DIV_STEPS   = 50;
  localparam int TIME_BITS   = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_step;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic [1:0] n_res;
  } stat_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  event_res;
    logic [63:0] stream_id_out;
    logic [39:0] frame_time_ms;
    logic [39:0] happen_time_ms;
    logic [31:0] avg_fps;
    logic [31:0] slow_gap_count;
    logic [39:0] interval_latency_ms;
  } res_t;

endpackage

// ===== design/vfjm_ctrl.sv =====
module vfjm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_tready,
  input  vfjm_pkg::stat_t   st,
  output vfjm_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_sel,
  output logic              out_last
);

  vfjm_pkg::state_t state_r, state_nxt;
  logic two_r, two_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    two_nxt   = two_r;
    case (state_r)
      vfjm_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = vfjm_pkg::ST_EXEC;
      end
      vfjm_pkg::ST_EXEC: begin
        two_nxt = (st.n_res == 2'd2);
        if (st.need_div) state_nxt = vfjm_pkg::ST_DIV;
        else if (st.n_res != 2'd0) state_nxt = vfjm_pkg::ST_EMIT0;
        else state_nxt = vfjm_pkg::ST_IDLE;
      end
      vfjm_pkg::ST_DIV: begin
        if (st.div_done) state_nxt = vfjm_pkg::ST_EMIT0;
      end
      vfjm_pkg::ST_EMIT0: begin
        if (out_tready) state_nxt = two_r ? vfjm_pkg::ST_EMIT1 : vfjm_pkg::ST_IDLE;
      end
      vfjm_pkg::ST_EMIT1: begin
        if (out_tready) state_nxt = vfjm_pkg::ST_IDLE;
      end
      default: state_nxt = vfjm_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_sel   = 1'b0;
    out_last  = 1'b0;
    case (state_r)
      vfjm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      vfjm_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = st.need_div;
      end
      vfjm_pkg::ST_DIV: cmd.div_step = 1'b1;
      vfjm_pkg::ST_EMIT0: begin
        out_valid = 1'b1;
        out_last  = !two_r;
      end
      vfjm_pkg::ST_EMIT1: begin
        out_valid = 1'b1;
        out_sel   = 1'b1;
        out_last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfjm_pkg::ST_IDLE;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      two_r   <= two_nxt;
    end
  end

endmodule

// ===== design/vfjm_dp.sv =====
module vfjm_dp #(
  parameter int WATCH_CAP = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vfjm_pkg::cmd_t    cmd,
  output vfjm_pkg::stat_t   st,
  input  logic [1:0]        in_kind,
  input  logic [63:0]       in_id,
  input  logic [31:0]       in_seq,
  input  logic [39:0]       in_now,
  input  logic [31:0]       in_thr,
  input  logic              in_edge,
  input  logic [15:0]       notify_ms,
  input  logic [15:0]       idle_ms,
  input  logic [15:0]       record_ms,
  input  logic [15:0]       stale_ms,
  input  logic              out_sel,
  output vfjm_pkg::res_t    res
);

  localparam int WI = (WATCH_CAP > 1) ? $clog2(WATCH_CAP) : 1;
  localparam int FD = vfjm_pkg::FIRST_DEPTH;
  localparam logic [39:0] M40 = '1;
  localparam logic [31:0] M32 = '1;
  localparam logic [39:0] TMASK = 40'(({64{1'b1}}) >> (64 - vfjm_pkg::TIME_BITS));

  // Latched input item.
  logic [1:0]  kind_r;
  logic [63:0] id_r;
  logic [31:0] seq_r, thr_r;
  logic [39:0] now_r;
  logic        edge_r;

  // Watch table.
  logic [WATCH_CAP-1:0] wv_r, wv_nxt;
  logic [63:0] wid_r [WATCH_CAP];
  logic [31:0] wthr_r [WATCH_CAP];
  logic [39:0] wstart_r [WATCH_CAP];
  logic [39:0] wpf_r [WATCH_CAP];
  logic [39:0] wpn_r [WATCH_CAP];
  logic [31:0] wdec_r [WATCH_CAP];
  logic [31:0] wps_r [WATCH_CAP];
  logic [31:0] wgc_r [WATCH_CAP];
  logic [39:0] wgs_r [WATCH_CAP];

  // First-frame table.
  logic [FD-1:0] fv_r, fv_nxt;
  logic [63:0] fid_r [FD];
  logic [39:0] ftime_r [FD];
  logic [31:0] fseq_r [FD];
  logic        fpend_r [FD];

  logic        coll_r, coll_nxt;
  logic [63:0] recent_r, recent_nxt;
  logic [31:0] idle_r, idle_nxt;

  // Results and divider.
  vfjm_pkg::res_t r0_r, r1_r, r0_nxt, r1_nxt;
  logic [1:0] n_nxt;
  logic [1:0] n_r;
  logic       need_div;
  logic [49:0] dividend_r;
  logic [39:0] divisor_r;
  logic [40:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [49:0] div_num;
  logic [39:0] div_den;
  logic [40:0] rem_sh;

  // Watch-table and first-frame-table write controls.
  logic          w_init, w_note, w_gap, w_notify;
  logic [WI-1:0] w_idx;
  logic          f_ins, f_sec, f_upd;
  logic [3:0]    f_idx;
  logic          t_notify;

  // Searches.
  logic          w_hit, r_hit, w_free_any;
  logic [WI-1:0] w_hidx, r_idx, w_free;
  logic          f_hit, f_free_any;
  logic [3:0]    f_hidx, f_old, f_free;
  logic [3:0]    f_cnt;
  logic [FD-1:0] fv_ev;

  always_comb begin
    w_hit = 1'b0; w_hidx = '0; r_hit = 1'b0; r_idx = '0;
    for (int i = WATCH_CAP - 1; i >= 0; i--) begin
      if (wv_r[i] && wid_r[i] == id_r) begin
        w_hit = 1'b1; w_hidx = WI'(i);
      end
      if (wv_r[i] && wid_r[i] == recent_r) begin
        r_hit = 1'b1; r_idx = WI'(i);
      end
    end
    f_hit = 1'b0; f_hidx = '0; f_cnt = '0;
    for (int i = FD - 1; i >= 0; i--) begin
      if (fv_r[i] && fid_r[i] == id_r) begin
        f_hit = 1'b1; f_hidx = 4'(i);
      end
    end
    // Oldest entry, ties to smallest id, earliest index.
    f_old = '0;
    for (int i = 0; i < FD; i++) begin
      if (fv_r[i]) begin
        f_cnt = f_cnt + 4'd1;
        if (!fv_r[f_old] || ftime_r[i] < ftime_r[f_old] ||
            (ftime_r[i] == ftime_r[f_old] && fid_r[i] < fid_r[f_old]))
          f_old = 4'(i);
      end
    end
    fv_ev = fv_r;
    if (f_cnt > 4'(vfjm_pkg::FIRST_LIMIT)) fv_ev[f_old] = 1'b0;
    f_free_any = 1'b0; f_free = '0;
    for (int i = FD - 1; i >= 0; i--) begin
      if (!fv_ev[i]) begin
        f_free_any = 1'b1; f_free = 4'(i);
      end
    end
  end

  // Free slot after an optional start-edge clear.
  logic in_edge_eff;
  assign in_edge_eff = edge_r;
  logic [WATCH_CAP-1:0] wv_base;
  always_comb begin
    wv_base = (in_edge_eff) ? '0 : wv_r;
    w_free_any = 1'b0; w_free = '0;
    for (int i = WATCH_CAP - 1; i >= 0; i--) begin
      if (!wv_base[i]) begin
        w_free_any = 1'b1; w_free = WI'(i);
      end
    end
  end

  // Differences with sign.
  function automatic logic [40:0] lapse(input logic [39:0] a, input logic [39:0] b);
    lapse = {1'b0, a} - {1'b0, b};
  endfunction

  logic [40:0] d_gap, d_since, d_start, d_ff, d_rgap, d_rsince;
  logic [WI-1:0] wh;
  assign wh = w_hidx;
  assign d_gap    = lapse(now_r, wpf_r[wh]);
  assign d_since  = lapse(now_r, wpn_r[wh]);
  assign d_start  = lapse(now_r, wstart_r[wh]);
  assign d_ff     = lapse(now_r, ftime_r[f_hidx]);
  assign d_rgap   = lapse(now_r, wpf_r[r_idx]);
  assign d_rsince = lapse(now_r, wpn_r[r_idx]);

  function automatic vfjm_pkg::res_t mk(input logic [1:0] ev, input logic [63:0] id,
                                        input logic [39:0] ft, input logic [39:0] ht);
    vfjm_pkg::res_t r;
    r = '0;
    r.event_res = ev; r.stream_id_out = id; r.frame_time_ms = ft; r.happen_time_ms = ht;
    mk = r;
  endfunction

  // Main execution step.
  always_comb begin
    wv_nxt = wv_r; fv_nxt = fv_r;
    coll_nxt = coll_r; recent_nxt = recent_r; idle_nxt = idle_r;
    r0_nxt = '0; r1_nxt = '0; n_nxt = '0; need_div = 1'b0;
    w_init = 1'b0; w_note = 1'b0; w_gap = 1'b0; w_notify = 1'b0;
    w_idx = w_hidx; f_ins = 1'b0; f_sec = 1'b0; f_upd = 1'b0; f_idx = f_hidx;
    t_notify = 1'b0;
    div_num = '0; div_den = '0;
    case (kind_r)
      vfjm_pkg::KIND_START: begin
        if (edge_r) begin
          wv_nxt = '0; idle_nxt = '0; recent_nxt = '0; coll_nxt = 1'b1;
        end
        if (w_hit && !edge_r) begin
          w_init = 1'b1; w_idx = w_hidx;
        end else if (w_free_any) begin
          w_init = 1'b1; w_idx = w_free;
        end
        if (w_init) wv_nxt[w_idx] = 1'b1;
      end
      vfjm_pkg::KIND_STOP: begin
        if (f_hit) fv_nxt[f_hidx] = 1'b0;
        if (w_hit && !d_start[40] && d_start[39:0] > 40'(notify_ms)) begin
          need_div = 1'b1;
          n_nxt = 2'd1;
          r0_nxt = mk(vfjm_pkg::EV_STATS, id_r, d_start[39:0], wstart_r[wh]);
          r0_nxt.slow_gap_count = wgc_r[wh];
          r0_nxt.interval_latency_ms = wgs_r[wh];
          // Decoded frames times 1000 as 1024 - 16 - 8.
          div_num = 50'({wdec_r[wh], 10'd0}) - 50'({wdec_r[wh], 4'd0})
                    - 50'({wdec_r[wh], 3'd0});
          div_den = d_start[39:0];
        end
        if (edge_r) begin
          wv_nxt = '0; coll_nxt = 1'b0; recent_nxt = '0; idle_nxt = '0;
        end
      end
      vfjm_pkg::KIND_FRAME: begin
        if (!f_hit) begin
          fv_nxt = fv_ev;
          f_ins = f_free_any; f_idx = f_free;
          if (f_free_any) fv_nxt[f_free] = 1'b1;
          r0_nxt = mk(vfjm_pkg::EV_FIRST, id_r, '0, now_r);
          n_nxt = 2'd1;
        end else if (fseq_r[f_hidx] != seq_r && fpend_r[f_hidx]) begin
          r0_nxt = mk(vfjm_pkg::EV_SECOND, id_r, d_ff[40] ? '0 : d_ff[39:0], now_r);
          n_nxt = 2'd1;
          f_sec = 1'b1;
        end else if (fseq_r[f_hidx] != seq_r) begin
          f_upd = 1'b1;
        end
        if (coll_r && w_hit) begin
          recent_nxt = id_r; idle_nxt = '0;
          if (wps_r[wh] == '0) w_note = 1'b1;
          else if (wps_r[wh] != seq_r) begin
            w_note = 1'b1;
            if (!d_since[40] && d_since[39:0] >= 40'(notify_ms)) begin
              w_gap = !d_gap[40] && d_gap[39:0] > 40'(record_ms);
              if (!d_gap[40] && d_gap[39:0] > 40'(wthr_r[wh])) begin
                w_notify = 1'b1;
                if (n_nxt == 2'd0) r0_nxt = mk(vfjm_pkg::EV_JANK, id_r, d_gap[39:0], now_r);
                else r1_nxt = mk(vfjm_pkg::EV_JANK, id_r, d_gap[39:0], now_r);
                n_nxt = n_nxt + 2'd1;
              end
            end
          end
        end
      end
      default: begin
        logic any;
        any = 1'b0;
        if (coll_r && r_hit && idle_r == '0 && !d_rsince[40] &&
            d_rsince[39:0] >= 40'(notify_ms) && !d_rgap[40] &&
            d_rgap[39:0] >= 40'(idle_ms)) begin
          t_notify = 1'b1;
          idle_nxt = idle_r + 32'd1;
          r0_nxt = mk(vfjm_pkg::EV_JANK, recent_r, d_rgap[39:0], now_r);
          n_nxt = 2'd1;
        end
        for (int i = 0; i < FD; i++) begin
          if (fv_r[i] && now_r >= ftime_r[i] && (now_r - ftime_r[i]) >= 40'(stale_ms))
            fv_nxt[i] = 1'b0;
        end
        if (coll_r) begin
          for (int i = 0; i < WATCH_CAP; i++) begin
            if (wv_r[i]) begin
              if (wpf_r[i] != '0 && now_r >= wpf_r[i] &&
                  (now_r - wpf_r[i]) >= 40'(stale_ms))
                wv_nxt[i] = 1'b0;
              else any = 1'b1;
            end
          end
          if (!any) begin
            wv_nxt = '0; coll_nxt = 1'b0; recent_nxt = '0; idle_nxt = '0;
          end
        end
      end
    endcase
  end

  // Control-state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0; fv_r <= '0; coll_r <= 1'b0; recent_r <= '0; idle_r <= '0; n_r <= '0;
    end else if (cmd.exec) begin
      wv_r <= wv_nxt; fv_r <= fv_nxt; coll_r <= coll_nxt;
      recent_r <= recent_nxt; idle_r <= idle_nxt; n_r <= n_nxt;
    end
  end

  // Payload registers.
  logic [40:0] gs_add;
  assign gs_add = {1'b0, wgs_r[wh]} + {1'b0, d_gap[39:0]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind; id_r <= in_id; seq_r <= in_seq;
      now_r <= in_now & TMASK; thr_r <= in_thr; edge_r <= in_edge;
    end
    if (cmd.exec) begin
      r0_r <= r0_nxt; r1_r <= r1_nxt;
      if (w_init) begin
        wid_r[w_idx] <= id_r; wthr_r[w_idx] <= thr_r; wstart_r[w_idx] <= now_r;
        wpf_r[w_idx] <= '0; wpn_r[w_idx] <= '0; wdec_r[w_idx] <= '0;
        wps_r[w_idx] <= '0; wgc_r[w_idx] <= '0; wgs_r[w_idx] <= '0;
      end
      if (w_note) begin
        if (wdec_r[wh] != M32) wdec_r[wh] <= wdec_r[wh] + 32'd1;
        wps_r[wh] <= seq_r; wpf_r[wh] <= now_r;
      end
      if (w_gap) begin
        if (wgc_r[wh] != M32) wgc_r[wh] <= wgc_r[wh] + 32'd1;
        wgs_r[wh] <= gs_add[40] ? M40 : gs_add[39:0];
      end
      if (w_notify) wpn_r[wh] <= now_r;
      if (t_notify) wpn_r[r_idx] <= now_r;
      if (f_ins) begin
        fid_r[f_idx] <= id_r; ftime_r[f_idx] <= now_r;
        fseq_r[f_idx] <= seq_r; fpend_r[f_idx] <= 1'b1;
      end
      if (f_sec) begin
        ftime_r[f_idx] <= now_r; fseq_r[f_idx] <= seq_r; fpend_r[f_idx] <= 1'b0;
      end
      if (f_upd) ftime_r[f_idx] <= now_r;
    end
    // Restoring divider, one quotient bit a cycle.
    if (cmd.div_start) begin
      dividend_r <= div_num; divisor_r <= div_den; rem_r <= '0;
      dcnt_r <= 6'(vfjm_pkg::DIV_STEPS);
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (rem_sh >= {1'b0, divisor_r}) begin
        rem_r <= rem_sh - {1'b0, divisor_r};
        dividend_r <= {dividend_r[48:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dividend_r <= {dividend_r[48:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 6'd1;
    end
  end
  assign rem_sh = {rem_r[39:0], dividend_r[49]};

  // Status and result selection.
  always_comb begin
    st.need_div = need_div;
    st.div_done = (dcnt_r == 6'd1);
    st.n_res    = n_nxt;
    res = out_sel ? r1_r : r0_r;
    if (!out_sel && r0_r.event_res == vfjm_pkg::EV_STATS && n_r != '0)
      res.avg_fps = (dividend_r[49:32] != '0) ? M32 : dividend_r[31:0];
  end

endmodule

// ===== design/video_frame_jank_monitor.sv =====
// Channel | Dir | Contents
// in_     | in  | tdata {report_threshold_ms, now_ms, sequence_req, stream_id}, tuser kind,
//         |     | tlast list_edge
// out_    | out | tdata {interval_latency_ms .. stream_id_out}, tuser event_res, tlast last
// cfg_    | in  | index 0..3 and 16-bit value, always ready
// An item is loaded, executed and then emitted one result at a time; a stats record
// first runs through the bit-serial divider for average fps.
// Reset is synchronous, active low, and empties both tables.
// A stalled output holds the block; no new item is taken until all results leave.
module video_frame_jank_monitor #(
  parameter int WATCH_CAP = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // stream_id, sequence_req, now_ms, report_threshold_ms
  input  logic [1:0]   in_tuser,   // kind
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // stream_id_out, frame_time_ms, happen_time_ms, avg_fps, slow_gap_count,
  // interval_latency_ms
  output logic [247:0] out_tdata,
  output logic [1:0]   out_tuser,  // event_res
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  vfjm_pkg::cmd_t  cmd;
  vfjm_pkg::stat_t st;
  vfjm_pkg::res_t  res;
  logic            out_sel;
  logic [15:0]     notify_r, idle_r, record_r, stale_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_r <= 16'd1000; idle_r <= 16'd300; record_r <= 16'd300; stale_r <= 16'd6000;
    end else if (cfg_valid) begin
      case (cfg_index)
        vfjm_pkg::REG_NOTIFY: notify_r <= cfg_data;
        vfjm_pkg::REG_IDLE:   idle_r   <= cfg_data;
        vfjm_pkg::REG_RECORD: record_r <= cfg_data;
        vfjm_pkg::REG_STALE:  stale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  vfjm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .out_tready(out_tready),
    .st(st), .cmd(cmd), .in_ready(in_tready), .out_valid(out_tvalid),
    .out_sel(out_sel), .out_last(out_tlast)
  );

  vfjm_dp #(.WATCH_CAP(WATCH_CAP)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_kind(in_tuser), .in_id(in_tdata[63:0]), .in_seq(in_tdata[95:64]),
    .in_now(in_tdata[135:96]), .in_thr(in_tdata[167:136]), .in_edge(in_tlast),
    .notify_ms(notify_r), .idle_ms(idle_r), .record_ms(record_r), .stale_ms(stale_r),
    .out_sel(out_sel), .res(res)
  );

  assign out_tuser = res.event_res;
  assign out_tdata = {res.interval_latency_ms, res.slow_gap_count, res.avg_fps,
                      res.happen_time_ms, res.frame_time_ms, res.stream_id_out};

endmodule

// ===== design/vfjm_checker.sv =====
module vfjm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast
);

  // The block never takes an item while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while result pending");

  // An accepted item is never followed by a result in the next cycle.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tlast)))
    else $error("result dropped");

endmodule

bind video_frame_jank_monitor vfjm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast)
);
